### hdl/b92_pkg.sv
// Shared types, constants and the character map for the base-92 block encoder.
package b92_pkg;

  localparam int unsigned BLOCK_BYTES = 5;
  localparam int unsigned BLOCK_CHARS = 7;
  localparam int unsigned DIGIT_W     = 7;
  localparam int unsigned VALUE_W     = 8 * BLOCK_BYTES;
  localparam int unsigned COUNT_W     = 3;
  localparam int unsigned EMIT_CNT_W  = $clog2(BLOCK_CHARS + 1);
  localparam int unsigned MARK_COUNT  = 29;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef digit_t [BLOCK_CHARS-1:0] digits_t;

  typedef struct packed {
    digits_t digits;
    logic    fin;
  } block_t;

  // Punctuation marks for digits 62 to 90, in order.
  localparam logic [7:0] MARK_CHARS [MARK_COUNT] = '{
    8'h2D, 8'h2B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h5E, 8'h26, 8'h2A, 8'h28,
    8'h29, 8'h5F, 8'h3D, 8'h3C, 8'h3E, 8'h2C, 8'h2F, 8'h27, 8'h7B, 8'h7D,
    8'h5B, 8'h3F, 8'h60, 8'h7E, 8'h7C, 8'h2E, 8'h5C, 8'h3B, 8'h3A
  };

  function automatic logic [7:0] digit_char(input digit_t d);
    logic [7:0] dc;
    logic [7:0] c;
    digit_t     m;
    dc = {1'b0, d};
    m  = d - digit_t'(62);
    if (d < digit_t'(26)) begin
      c = dc + 8'h61;
    end else if (d < digit_t'(52)) begin
      c = dc - 8'd26 + 8'h41;
    end else if (d < digit_t'(62)) begin
      c = dc - 8'd52 + 8'h30;
    end else if (d < digit_t'(91)) begin
      c = MARK_CHARS[m[4:0]];
    end else begin
      c = 8'h00;
    end
    return c;
  endfunction

endpackage

### hdl/b92_gather.sv
// Byte gathering: collects big-endian bytes and hands a zero-padded block on.
module b92_gather (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [7:0]                  data_byte,
  input  logic                        final_byte,
  input  logic                        conv_free,
  output logic                        in_stall,
  output logic                        load,
  output logic [b92_pkg::VALUE_W-1:0] load_value,
  output logic                        load_fin
);
  import b92_pkg::*;

  logic [31:0]        gathered;
  logic [31:0]        gathered_next;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic               full;
  logic               close;
  logic               accept;

  assign full     = count >= COUNT_W'(BLOCK_BYTES - 1);
  assign close    = final_byte | full;
  assign in_stall = close & ~conv_free;
  assign accept   = in_valid & ~in_stall;
  assign load     = accept & close;
  assign load_fin = final_byte;

  // Pad missing low bytes with zeros
  always_comb begin
    case (count)
      3'd0:    load_value = {data_byte, 32'h0};
      3'd1:    load_value = {gathered[7:0], data_byte, 24'h0};
      3'd2:    load_value = {gathered[15:0], data_byte, 16'h0};
      3'd3:    load_value = {gathered[23:0], data_byte, 8'h0};
      default: load_value = {gathered, data_byte};
    endcase
  end

  always_comb begin
    gathered_next = gathered;
    count_next    = count;
    if (load) begin
      gathered_next = '0;
      count_next    = '0;
    end else if (accept) begin
      gathered_next = {gathered[23:0], data_byte};
      count_next    = count + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gathered <= '0;
      count    <= '0;
    end else begin
      gathered <= gathered_next;
      count    <= count_next;
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(BLOCK_BYTES - 1))
    else $error("open block holds more than four bytes");
`endif

endmodule

### hdl/b92_conv.sv
// Radix converter: shifts a 40-bit block into seven base-92 digits, a byte a cycle.
module b92_conv (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic [b92_pkg::VALUE_W-1:0] load_value,
  input  logic                        load_fin,
  input  logic                        take,
  output logic                        conv_free,
  output logic                        done,
  output b92_pkg::block_t             blk
);
  import b92_pkg::*;

  typedef enum logic [2:0] {
    CV_IDLE = 3'b001,
    CV_RUN  = 3'b010,
    CV_DONE = 3'b100
  } cv_state_t;

  cv_state_t          state;
  cv_state_t          state_next;
  logic [VALUE_W-1:0] value;
  logic [COUNT_W-1:0] step;
  digits_t            digits;
  logic               fin;

  // Doubling with base-92 carries, one input bit per pass
  function automatic digits_t shift_in_byte(input digits_t d, input logic [7:0] b);
    digits_t                r;
    logic [BLOCK_CHARS-1:0] cout;
    digit_t                 t;
    r = d;
    for (int j = 7; j >= 0; j--) begin
      for (int i = 0; i < BLOCK_CHARS; i++) begin
        cout[i] = r[i] >= digit_t'(46);
      end
      for (int i = 0; i < BLOCK_CHARS; i++) begin
        t    = cout[i] ? (r[i] - digit_t'(46)) : r[i];
        r[i] = {t[DIGIT_W-2:0], (i == 0) ? b[j] : cout[(i == 0) ? 0 : i - 1]};
      end
    end
    return r;
  endfunction

  assign done       = state == CV_DONE;
  assign conv_free  = (state == CV_IDLE) | (done & take);
  assign blk.digits = digits;
  assign blk.fin    = fin;

  always_comb begin
    state_next = state;
    if (load) begin
      state_next = CV_RUN;
    end else begin
      case (state)
        CV_IDLE: state_next = CV_IDLE;
        CV_RUN: begin
          if (step == COUNT_W'(BLOCK_BYTES - 1)) state_next = CV_DONE;
        end
        CV_DONE: begin
          if (take) state_next = CV_IDLE;
        end
        default: state_next = CV_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value  <= load_value;
      digits <= '0;
      step   <= '0;
      fin    <= load_fin;
    end else if (state == CV_RUN) begin
      value  <= {value[VALUE_W-9:0], 8'h0};
      digits <= shift_in_byte(digits, value[VALUE_W-1 -: 8]);
      step   <= step + COUNT_W'(1);
    end
  end

`ifndef SYNTH
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> conv_free)
    else $error("block loaded while converter occupied");
  a_load_runs: assert property (@(posedge clk) disable iff (rst)
    load |=> (state == CV_RUN) && (step == '0))
    else $error("load did not start a conversion");
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (state == CV_RUN) && (step == COUNT_W'(BLOCK_BYTES - 1)) && !load |=> done)
    else $error("conversion did not finish after five bytes");
`endif

endmodule

### hdl/b92_emit.sv
// Result register: maps digits to characters and sends them most significant first.
module b92_emit (
  input  logic            clk,
  input  logic            rst,
  input  logic            done,
  input  b92_pkg::block_t blk,
  input  logic            out_stall,
  output logic            take,
  output logic            out_valid,
  output logic [7:0]      out_char,
  output logic            block_end,
  output logic            message_end
);
  import b92_pkg::*;

  logic [7:0]            chars [BLOCK_CHARS];
  logic [EMIT_CNT_W-1:0] cnt;
  logic                  fin;
  logic                  out_acc;
  logic                  last;

  assign out_valid   = cnt != '0;
  assign out_acc     = out_valid & ~out_stall;
  assign last        = cnt == EMIT_CNT_W'(1);
  assign take        = done & (~out_valid | (last & out_acc));
  assign out_char    = chars[0];
  assign block_end   = last;
  assign message_end = last & fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (take) begin
      cnt <= EMIT_CNT_W'(BLOCK_CHARS);
    end else if (out_acc) begin
      cnt <= cnt - EMIT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fin <= blk.fin;
      for (int i = 0; i < BLOCK_CHARS; i++) begin
        chars[i] <= digit_char(blk.digits[BLOCK_CHARS-1-i]);
      end
    end else if (out_acc) begin
      for (int i = 0; i < BLOCK_CHARS - 1; i++) begin
        chars[i] <= chars[i+1];
      end
    end
  end

`ifndef SYNTH
  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid && (cnt == EMIT_CNT_W'(BLOCK_CHARS)))
    else $error("taken block not loaded into result register");
  a_msg_in_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && message_end |-> block_end)
    else $error("message end outside block end");
`endif

endmodule

### hdl/base92_block_encoder_core.sv
// Top level of the base-92 block encoder: gather, convert and emit stages.
// Flow: the closing byte of a block loads the converter, whose digits pass to the result register;
//   the seven characters then follow one a cycle while out_stall is low.
// Throughput: one byte a cycle while a block gathers and in_stall is low; the block rate is
//   bounded by the one-character-per-cycle result register.
// Reset: synchronous rst empties the open block, the converter and the result register.
module base92_block_encoder_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       block_end,
  output logic       message_end
);
  import b92_pkg::*;

  // Gather -> converter request
  logic               load;
  logic [VALUE_W-1:0] load_value;
  logic               load_fin;
  logic               conv_free;

  // Converter -> result register request
  logic               done;
  logic               take;
  block_t             blk;

  // Hold bytes of the open block; on the closing byte, pad with zeros and
  // stall only that byte while the converter is still occupied.
  b92_gather u_gather (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .conv_free  (conv_free),
    .in_stall   (in_stall),
    .load       (load),
    .load_value (load_value),
    .load_fin   (load_fin)
  );

  // Advance one byte per cycle into the base-92 digit register, then hold the
  // digits until the result register takes them.
  b92_conv u_conv (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .load_value (load_value),
    .load_fin   (load_fin),
    .take       (take),
    .conv_free  (conv_free),
    .done       (done),
    .blk        (blk)
  );

  // Map digits to characters and drain them most significant first; a new
  // block is taken in the cycle its predecessor's last character leaves.
  b92_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .done        (done),
    .blk         (blk),
    .out_stall   (out_stall),
    .take        (take),
    .out_valid   (out_valid),
    .out_char    (out_char),
    .block_end   (block_end),
    .message_end (message_end)
  );

endmodule

### dv/tb_base92_block_encoder_core.sv
// Self-checking testbench for the base-92 block encoder: directed table, then random messages.
`timescale 1ns / 1ps

module tb_base92_block_encoder_core;

  localparam int unsigned NCHARS        = b92_pkg::BLOCK_CHARS;
  localparam int          DIRECTED_ROWS = 25;
  localparam int          RANDOM_BYTES  = 400;
  localparam int          CYCLE_LIMIT   = 200000;
  localparam int          HOLD_OFF_LEN  = 250;
  localparam int          DRAIN_CYCLES  = 40;
  localparam int          PRINT_CAP     = 40;

  // Digits 0 to 90 as character codes, first digit in the top byte; digit 91 is 0x00.
  localparam logic [8*91-1:0] DIGIT_ALPHABET =
    {"abcdefghijklmnopqrstuvwxyz", "ABCDEFGHIJKLMNOPQRSTUVWXYZ",
     "0123456789", "-+!@#$^&*()_=<>,/'{}[?`~|.\\;:"};

  typedef struct packed {
    logic [7:0]  data;
    logic        fin;
    logic        typed;
    logic [55:0] chars;
  } byte_request_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       bend;
    logic       mend;
  } enc_char_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] data_byte;
  logic       final_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_char;
  logic       block_end;
  logic       message_end;

  // Predictor state: bytes of the open block, right-aligned, and how many there are.
  logic [31:0] open_bytes;
  int          open_count;

  enc_char_t   pending_chars [$];
  int          mismatches;
  int          cycles;
  int          burst_left;
  int          bytes_sent;
  int          messages_sent;
  int          chars_checked;
  int          blocks_checked;
  int          input_stall_cycles;
  bit          random_phase;

  // Directed table: typed expectations only where the characters are obvious.
  byte_request_t directed_rows [DIRECTED_ROWS] = '{
    // one zero byte flagged final: a one-byte block padded with zeros
    '{8'h00, 1'b1, 1'b1, "aaaaaaa"},
    // value 91 in the last digit: the character that maps to 0x00
    '{8'h00, 1'b0, 1'b0, 56'h0},
    '{8'h00, 1'b0, 1'b0, 56'h0},
    '{8'h00, 1'b0, 1'b0, 56'h0},
    '{8'h00, 1'b0, 1'b0, 56'h0},
    '{8'h5B, 1'b0, 1'b1, {"aaaaaa", 8'h00}},
    // final flag on the fifth byte: a full block that also ends the message
    '{8'h00, 1'b0, 1'b0, 56'h0},
    '{8'h00, 1'b0, 1'b0, 56'h0},
    '{8'h00, 1'b0, 1'b0, 56'h0},
    '{8'h00, 1'b0, 1'b0, 56'h0},
    '{8'h5A, 1'b1, 1'b1, "aaaaaa:"},
    // largest block value
    '{8'hFF, 1'b0, 1'b0, 56'h0},
    '{8'hFF, 1'b0, 1'b0, 56'h0},
    '{8'hFF, 1'b0, 1'b0, 56'h0},
    '{8'hFF, 1'b0, 1'b0, 56'h0},
    '{8'hFF, 1'b0, 1'b0, 56'h0},
    // short blocks of two, three and four bytes
    '{8'h80, 1'b0, 1'b0, 56'h0},
    '{8'h01, 1'b1, 1'b0, 56'h0},
    '{8'h12, 1'b0, 1'b0, 56'h0},
    '{8'h34, 1'b0, 1'b0, 56'h0},
    '{8'h56, 1'b1, 1'b0, 56'h0},
    '{8'hAB, 1'b0, 1'b0, 56'h0},
    '{8'hCD, 1'b0, 1'b0, 56'h0},
    '{8'hEF, 1'b0, 1'b0, 56'h0},
    '{8'h7F, 1'b1, 1'b0, 56'h0}
  };

  base92_block_encoder_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .final_byte  (final_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_char    (out_char),
    .block_end   (block_end),
    .message_end (message_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // Guard against a hung block: fail the run outright past the limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d characters still awaited", cycles,
               pending_chars.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_stall) begin
      input_stall_cycles <= input_stall_cycles + 1;
    end
  end

  function automatic logic [7:0] digit_code(input int unsigned d);
    if (d >= 91) begin
      return 8'h00;
    end
    return DIGIT_ALPHABET[8*(90-d) +: 8];
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_CAP) begin
      $display("[%0t] mismatch in %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  // Update the open block with one accepted request; on a closing byte, queue the
  // seven characters of the block, most significant digit first.
  task automatic encode_request(input byte_request_t req);
    logic [39:0] block_value;
    logic [7:0]  digit_chars [NCHARS];
    enc_char_t   ec;
    int          k;
    if (!req.fin && open_count < 4) begin
      open_bytes = {open_bytes[23:0], req.data};
      open_count++;
      return;
    end
    block_value = {open_bytes, req.data};
    block_value = block_value << (8 * (4 - open_count));
    for (k = NCHARS - 1; k >= 0; k--) begin
      digit_chars[k] = digit_code(int'(block_value % 40'd92));
      block_value    = block_value / 40'd92;
    end
    for (k = 0; k < NCHARS; k++) begin
      ec.ch   = req.typed ? req.chars[55-8*k -: 8] : digit_chars[k];
      ec.bend = (k == NCHARS - 1);
      ec.mend = (k == NCHARS - 1) && req.fin;
      pending_chars.push_back(ec);
    end
    open_bytes = '0;
    open_count = 0;
  endtask

  // Offer one request in the current burst, opening a random gap when a burst runs
  // out; hold the payload until the block takes it.
  task automatic send_request(input byte_request_t req);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    data_byte  <= req.data;
    final_byte <= req.fin;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (req.fin) begin
      messages_sent++;
    end
    encode_request(req);
  endtask

  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Sender: directed table first, then random messages of random length.
  initial begin
    byte_request_t req;
    int            msg_len;
    int            i;
    in_valid     = 1'b0;
    data_byte    = 8'h00;
    final_byte   = 1'b0;
    open_bytes   = '0;
    open_count   = 0;
    mismatches   = 0;
    cycles       = 0;
    burst_left   = 0;
    bytes_sent   = 0;
    messages_sent = 0;
    random_phase = 1'b0;
    input_stall_cycles = 0;
    wait (!rst);
    @(posedge clk);

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      send_request(directed_rows[i]);
    end

    random_phase = 1'b1;
    while (bytes_sent < DIRECTED_ROWS + RANDOM_BYTES) begin
      // mostly whole messages; now and then a long one spanning several blocks
      msg_len = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 23) : $urandom_range(1, 11);
      for (i = 0; i < msg_len; i++) begin
        req.data  = random_byte();
        req.fin   = (i == msg_len - 1);
        req.typed = 1'b0;
        req.chars = '0;
        send_request(req);
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every queued character, then watch for strays.
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d messages; checked %0d characters in %0d blocks.",
             bytes_sent, messages_sent, chars_checked, blocks_checked);
    $display("Input held off for %0d cycles; %0d mismatches.", input_stall_cycles,
             mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Receiver: stall in stretches of varying density, and once hold off for a long
  // stretch so the block backs up into its input.
  initial begin
    int  mode;
    int  len;
    int  n;
    bit  held_off;
    out_stall = 1'b0;
    held_off  = 1'b0;
    wait (!rst);
    forever begin
      if (!held_off && random_phase) begin
        held_off = 1'b1;
        for (n = 0; n < HOLD_OFF_LEN; n++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      mode = $urandom_range(0, 3);
      len  = $urandom_range(5, 60);
      for (n = 0; n < len; n++) begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= 1'($urandom_range(0, 1));
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Check each accepted character against the oldest one awaited.
  always @(posedge clk) begin
    enc_char_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        report_mismatch("unexpected character", int'(out_char), 0);
      end else begin
        want = pending_chars.pop_front();
        if (out_char !== want.ch) begin
          report_mismatch("out_char", int'(out_char), int'(want.ch));
        end
        if (block_end !== want.bend) begin
          report_mismatch("block_end", int'(block_end), int'(want.bend));
        end
        if (message_end !== want.mend) begin
          report_mismatch("message_end", int'(message_end), int'(want.mend));
        end
        chars_checked++;
        if (want.bend) begin
          blocks_checked++;
        end
      end
    end
  end

endmodule
